// ===== rtl/core/prs_pkg.sv =====
// Shared types and constants for the periodic five-point residual block.
// No dependencies; used by the top level, the port checker and the testbench.
package prs_pkg;

    localparam int VAL_W         = 32;   // stored solution / rhs values, Q15.16
    localparam int RES_W         = 36;   // residual, Q19.16
    localparam int CFG_W         = 7;    // grid_side register
    localparam int COORD_W       = 6;    // row / col ports
    localparam int MIN_GRID_SIDE = 4;
    localparam int CENTER_SHIFT  = 2;    // centre weight of four

    localparam logic [CFG_W-1:0] GRID_SIDE_RESET = 7'd64;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // solution port sequencer: centre read on acceptance, then one neighbor a cycle
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_UP,
        SEQ_DOWN,
        SEQ_LEFT,
        SEQ_RIGHT
    } seq_state_t;

    // tags what the solution RAM returns in the current cycle
    typedef enum logic [1:0] {
        RD_NONE,
        RD_CENTER,
        RD_NEIGHBOR,
        RD_LAST
    } rd_kind_t;

endpackage

// ===== rtl/core/prs_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module prs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/core/poisson_residual_stencil.sv =====
// Five-point Laplacian residual on a periodic square grid held in two RAMs.
// Depends on prs_pkg and prs_ram.
//
//  channel   | ports                                         | flow control
//  ----------+-----------------------------------------------+-------------------------
//  config    | cfg_wr_en, cfg_wr_data                        | write on enable, no wait
//  command   | start, busy, action, row, col,                | transfer on start & !busy
//            | solution_value, rhs_value                     |
//  result    | residual_valid, residual                      | one-cycle strobe
//
// A load writes in its transfer cycle; busy stays low. A query holds the single solution
// port for its reads (centre, then up, down, left, right), so busy is high after its
// transfer until the right read issues, and no next command is taken before that. The
// residual strobes once the last read is accumulated, while the next command proceeds.
// Reset clears the sequencer and grid_side (to 64); RAM contents are not cleared.
// The receiver cannot stall; out-of-grid commands are dropped with no result.
module poisson_residual_stencil #(
    parameter int MAX_GRID_SIDE = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [prs_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                               start,
    output logic                               busy,
    input  logic                               action,
    input  logic [prs_pkg::COORD_W-1:0]        row,
    input  logic [prs_pkg::COORD_W-1:0]        col,
    input  logic signed [prs_pkg::VAL_W-1:0]   solution_value,
    input  logic signed [prs_pkg::VAL_W-1:0]   rhs_value,
    output logic signed [prs_pkg::RES_W-1:0]   residual,
    output logic                               residual_valid
);

    localparam int CELLS  = MAX_GRID_SIDE * MAX_GRID_SIDE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int IDX_W  = ($clog2(MAX_GRID_SIDE + 1) > prs_pkg::CFG_W) ?
                            $clog2(MAX_GRID_SIDE + 1) : prs_pkg::CFG_W;
    localparam int VW     = prs_pkg::VAL_W;
    localparam int RW     = prs_pkg::RES_W;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_GRID_SIDE) + ADDR_W'(c);
    endfunction

    logic [prs_pkg::CFG_W-1:0] grid_side_reg;
    logic [IDX_W-1:0]          grid_ext;
    logic [IDX_W-1:0]          side;
    logic [IDX_W-1:0]          row_ext;
    logic [IDX_W-1:0]          col_ext;
    logic                      in_range;
    logic                      accept;
    logic                      query_go;
    logic                      load_we;

    logic [IDX_W-1:0] row_reg, col_reg, up_row_reg, down_row_reg, left_col_reg, right_col_reg;
    logic [IDX_W-1:0] up_row_next, down_row_next, left_col_next, right_col_next;

    prs_pkg::seq_state_t state_reg, state_next;
    prs_pkg::rd_kind_t   kind_reg, kind_issue;
    logic [ADDR_W-1:0]   sol_addr;
    logic [ADDR_W-1:0]   cell_addr;
    logic [VW-1:0]       sol_rd;
    logic [VW-1:0]       rhs_rd;

    logic signed [RW-1:0] acc_reg, acc_next;
    logic signed [RW-1:0] residual_reg, residual_next;
    logic                 res_valid_reg, res_valid_next;
    logic signed [RW-1:0] sol_ext;
    logic signed [RW-1:0] rhs_ext;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg <= prs_pkg::GRID_SIDE_RESET;
        end
        else if (cfg_wr_en)
        begin
            grid_side_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        grid_ext = IDX_W'(grid_side_reg);
        if (grid_ext < IDX_W'(prs_pkg::MIN_GRID_SIDE))
        begin
            side = IDX_W'(prs_pkg::MIN_GRID_SIDE);
        end
        else if (grid_ext > IDX_W'(MAX_GRID_SIDE))
        begin
            side = IDX_W'(MAX_GRID_SIDE);
        end
        else
        begin
            side = grid_ext;
        end
    end

    // ---------------------------------------------------------------- command decode
    assign row_ext   = IDX_W'(row);
    assign col_ext   = IDX_W'(col);
    assign in_range  = (row_ext < side) && (col_ext < side);
    assign busy      = (state_reg != prs_pkg::SEQ_IDLE);
    assign accept    = start && !busy;
    assign query_go  = accept && (action == prs_pkg::ACT_QUERY) && in_range;
    assign load_we   = accept && (action == prs_pkg::ACT_LOAD) && in_range;
    assign cell_addr = addr_of(row_ext, col_ext);

    // periodic wrap of the neighbor indices
    always_comb
    begin
        up_row_next    = (row_ext == '0) ? side - IDX_W'(1) : row_ext - IDX_W'(1);
        down_row_next  = (row_ext + IDX_W'(1) == side) ? '0 : row_ext + IDX_W'(1);
        left_col_next  = (col_ext == '0) ? side - IDX_W'(1) : col_ext - IDX_W'(1);
        right_col_next = (col_ext + IDX_W'(1) == side) ? '0 : col_ext + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            row_reg       <= row_ext;
            col_reg       <= col_ext;
            up_row_reg    <= up_row_next;
            down_row_reg  <= down_row_next;
            left_col_reg  <= left_col_next;
            right_col_reg <= right_col_next;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prs_pkg::SEQ_IDLE;
            kind_reg  <= prs_pkg::RD_NONE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_issue;
        end
    end

    // Loads write in their transfer cycle and a query's reads all issue before the next
    // command is taken, so reads never overlap a pending write to the same cell.
    always_comb
    begin
        state_next = state_reg;
        kind_issue = prs_pkg::RD_NONE;
        sol_addr   = cell_addr;
        case (state_reg)
            prs_pkg::SEQ_IDLE:
            begin
                if (query_go)
                begin
                    state_next = prs_pkg::SEQ_UP;
                    kind_issue = prs_pkg::RD_CENTER;
                end
            end
            prs_pkg::SEQ_UP:
            begin
                sol_addr   = addr_of(up_row_reg, col_reg);
                kind_issue = prs_pkg::RD_NEIGHBOR;
                state_next = prs_pkg::SEQ_DOWN;
            end
            prs_pkg::SEQ_DOWN:
            begin
                sol_addr   = addr_of(down_row_reg, col_reg);
                kind_issue = prs_pkg::RD_NEIGHBOR;
                state_next = prs_pkg::SEQ_LEFT;
            end
            prs_pkg::SEQ_LEFT:
            begin
                sol_addr   = addr_of(row_reg, left_col_reg);
                kind_issue = prs_pkg::RD_NEIGHBOR;
                state_next = prs_pkg::SEQ_RIGHT;
            end
            prs_pkg::SEQ_RIGHT:
            begin
                sol_addr   = addr_of(row_reg, right_col_reg);
                kind_issue = prs_pkg::RD_LAST;
                state_next = prs_pkg::SEQ_IDLE;
            end
            default:
            begin
                state_next = prs_pkg::SEQ_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- memories
    prs_ram #(
        .WIDTH (VW),
        .DEPTH (CELLS)
    ) u_sol_ram (
        .clk   (clk),
        .we    (load_we),
        .addr  (sol_addr),
        .wdata (solution_value),
        .rdata (sol_rd)
    );

    prs_ram #(
        .WIDTH (VW),
        .DEPTH (CELLS)
    ) u_rhs_ram (
        .clk   (clk),
        .we    (load_we),
        .addr  (cell_addr),
        .wdata (rhs_value),
        .rdata (rhs_rd)
    );

    // ---------------------------------------------------------------- accumulate
    assign sol_ext = {{(RW - VW){sol_rd[VW-1]}}, sol_rd};
    assign rhs_ext = {{(RW - VW){rhs_rd[VW-1]}}, rhs_rd};

    always_comb
    begin
        acc_next       = acc_reg;
        residual_next  = residual_reg;
        res_valid_next = 1'b0;
        case (kind_reg)
            prs_pkg::RD_CENTER:
            begin
                acc_next = rhs_ext + (sol_ext <<< prs_pkg::CENTER_SHIFT);
            end
            prs_pkg::RD_NEIGHBOR:
            begin
                acc_next = acc_reg - sol_ext;
            end
            prs_pkg::RD_LAST:
            begin
                residual_next  = acc_reg - sol_ext;
                res_valid_next = 1'b1;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        residual_reg <= residual_next;
    end

    assign residual       = residual_reg;
    assign residual_valid = res_valid_reg;

endmodule

// ===== rtl/core/prs_checker.sv =====
// Port-level checks on command/result timing of poisson_residual_stencil.
// Depends on prs_pkg; bound to the top level at the end of this file.
module prs_checker #(
    parameter int MAX_GRID_SIDE = 64
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_wr_en,
    input logic [prs_pkg::CFG_W-1:0]          cfg_wr_data,
    input logic                               start,
    input logic                               busy,
    input logic                               action,
    input logic [prs_pkg::COORD_W-1:0]        row,
    input logic [prs_pkg::COORD_W-1:0]        col,
    input logic                               residual_valid
);

    localparam int IDX_W = ($clog2(MAX_GRID_SIDE + 1) > prs_pkg::CFG_W) ?
                           $clog2(MAX_GRID_SIDE + 1) : prs_pkg::CFG_W;

    logic [prs_pkg::CFG_W-1:0] side_reg;
    logic [IDX_W-1:0]          side_ext;
    logic [IDX_W-1:0]          side;
    logic                      q_acc;
    logic                      l_acc;

    // shadow of the grid side so in-grid queries can be recognized from the ports
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= prs_pkg::GRID_SIDE_RESET;
        end
        else if (cfg_wr_en)
        begin
            side_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        side_ext = IDX_W'(side_reg);
        if (side_ext < IDX_W'(prs_pkg::MIN_GRID_SIDE))
        begin
            side = IDX_W'(prs_pkg::MIN_GRID_SIDE);
        end
        else if (side_ext > IDX_W'(MAX_GRID_SIDE))
        begin
            side = IDX_W'(MAX_GRID_SIDE);
        end
        else
        begin
            side = side_ext;
        end
    end

    assign q_acc = rst_n && start && !busy && (action == prs_pkg::ACT_QUERY)
                   && (IDX_W'(row) < side) && (IDX_W'(col) < side);
    assign l_acc = rst_n && start && !busy && (action == prs_pkg::ACT_LOAD);

    // every in-grid query gives exactly one result; the strobe follows its transfer once
    // the centre and neighbor reads are summed and the result is registered
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (residual_valid == $past(q_acc, 6)))
        else $error("residual strobe does not match query transfer six edges earlier");

    // a query holds busy high after its transfer until its neighbor reads have issued
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_acc |=> busy ##1 busy ##1 busy ##1 busy ##1 !busy)
        else $error("busy window after a query is not four cycles");

    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        l_acc |=> !busy)
        else $error("busy raised after a load");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        residual_valid |=> !residual_valid)
        else $error("residual strobe held for more than one cycle");

endmodule

bind poisson_residual_stencil prs_checker #(
    .MAX_GRID_SIDE (MAX_GRID_SIDE)
) u_prs_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for poisson_residual_stencil: directed table, then random load/query phases.
// Depends on prs_pkg and the RTL; carries its own residual predictor and grid copy.
module testbench;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int MAX_SIDE      = 64;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int N_PHASES      = 12;
    localparam int PHASE_ITEMS   = 86;
    localparam int WINDOW        = 8;
    localparam int N_PLAN        = 23;

    localparam int VW  = prs_pkg::VAL_W;
    localparam int RW  = prs_pkg::RES_W;
    localparam int CFW = prs_pkg::CFG_W;
    localparam int CDW = prs_pkg::COORD_W;

    localparam logic A_LD  = prs_pkg::ACT_LOAD;
    localparam logic A_QRY = prs_pkg::ACT_QUERY;

    localparam logic [VW-1:0] V_MAX  = 32'h7FFF_FFFF;
    localparam logic [VW-1:0] V_MIN  = 32'h8000_0000;
    localparam logic [VW-1:0] V_ONE  = 32'h0001_0000;
    localparam logic [VW-1:0] V_HALF = 32'hFFFF_8000;

    typedef struct packed {
        logic                      action;
        logic [CDW-1:0]            row;
        logic [CDW-1:0]            col;
        logic signed [VW-1:0]      sol;
        logic signed [VW-1:0]      rhs;
    } stencil_cmd_t;

    typedef struct packed {
        logic [CFW-1:0]            side;
        logic                      action;
        logic [CDW-1:0]            row;
        logic [CDW-1:0]            col;
        logic [VW-1:0]             sol;
        logic [VW-1:0]             rhs;
        logic                      pinned;
        logic [RW-1:0]             res;
    } plan_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFW-1:0]             cfg_wr_data = '0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       action = A_LD;
    logic [CDW-1:0]             row = '0;
    logic [CDW-1:0]             col = '0;
    logic signed [VW-1:0]       solution_value = '0;
    logic signed [VW-1:0]       rhs_value = '0;
    logic signed [RW-1:0]       residual;
    logic                       residual_valid;

    // predictor state
    logic signed [VW-1:0]       sol_grid [MAX_SIDE*MAX_SIDE];
    logic signed [VW-1:0]       rhs_grid [MAX_SIDE*MAX_SIDE];
    bit                         loaded   [MAX_SIDE*MAX_SIDE];
    logic [CFW-1:0]             grid_cfg = prs_pkg::GRID_SIDE_RESET;

    logic signed [RW-1:0]       pending_residuals [$];
    int                         mismatches = 0;

    // a directed row may pin the expected residual instead of using the predictor
    bit                         pin_valid = 1'b0;
    logic signed [RW-1:0]       pin_res = '0;

    always #(CLK_PERIOD/2) clk = ~clk;

    poisson_residual_stencil #(.MAX_GRID_SIDE(MAX_SIDE)) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .row            (row),
        .col            (col),
        .solution_value (solution_value),
        .rhs_value      (rhs_value),
        .residual       (residual),
        .residual_valid (residual_valid)
    );

    function automatic int side_in_use();
        if (grid_cfg < prs_pkg::MIN_GRID_SIDE)
            return prs_pkg::MIN_GRID_SIDE;
        if (grid_cfg > MAX_SIDE)
            return MAX_SIDE;
        return int'(grid_cfg);
    endfunction

    // periodic wrap for an index that is at most one step outside the grid
    function automatic int wrap(int v, int s);
        if (v < 0)
            return s - 1;
        if (v >= s)
            return 0;
        return v;
    endfunction

    function automatic int addr_of(int r, int c);
        return r * MAX_SIDE + c;
    endfunction

    function automatic bit cell_ready(int r, int c);
        int s;
        s = side_in_use();
        return loaded[addr_of(r, c)]
            && loaded[addr_of(wrap(r - 1, s), c)] && loaded[addr_of(wrap(r + 1, s), c)]
            && loaded[addr_of(r, wrap(c - 1, s))] && loaded[addr_of(r, wrap(c + 1, s))];
    endfunction

    function automatic logic signed [RW-1:0] predict_residual(int r, int c);
        int     s;
        longint nsum;
        longint acc;
        s = side_in_use();
        nsum = longint'(sol_grid[addr_of(wrap(r - 1, s), c)])
             + longint'(sol_grid[addr_of(wrap(r + 1, s), c)])
             + longint'(sol_grid[addr_of(r, wrap(c - 1, s))])
             + longint'(sol_grid[addr_of(r, wrap(c + 1, s))]);
        acc = longint'(rhs_grid[addr_of(r, c)]) - nsum
            + 4 * longint'(sol_grid[addr_of(r, c)]);
        return acc[RW-1:0];
    endfunction

    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return V_MAX;
            1: return V_MIN;
            2: return '0;
            3: return VW'($signed($urandom_range(0, 255)) - 128);
            default: return $urandom;
        endcase
    endfunction

    function automatic stencil_cmd_t next_command(int sr, int sc, int span);
        stencil_cmd_t cmd;
        int           s;
        s = side_in_use();
        cmd.sol = pick_value();
        cmd.rhs = pick_value();
        if ($urandom_range(0, 99) < 8)
        begin
            // noise: anywhere, in or out of the grid
            cmd.action = $urandom_range(0, 1) ? A_QRY : A_LD;
            cmd.row = CDW'($urandom_range(0, (1 << CDW) - 1));
            cmd.col = CDW'($urandom_range(0, (1 << CDW) - 1));
        end
        else
        begin
            cmd.action = $urandom_range(0, 1) ? A_QRY : A_LD;
            cmd.row = CDW'((sr + $urandom_range(0, span - 1)) % s);
            cmd.col = CDW'((sc + $urandom_range(0, span - 1)) % s);
        end
        // never read a cell that was not loaded
        if (cmd.action == A_QRY && cmd.row < s && cmd.col < s
                && !cell_ready(cmd.row, cmd.col))
            cmd.action = A_LD;
        return cmd;
    endfunction

    task automatic take_command();
        int s;
        int addr;
        s = side_in_use();
        if (row < s && col < s)
        begin
            addr = addr_of(row, col);
            if (action == A_LD)
            begin
                sol_grid[addr] = solution_value;
                rhs_grid[addr] = rhs_value;
                loaded[addr] = 1'b1;
            end
            else
                pending_residuals.push_back(pin_valid ? pin_res : predict_residual(row, col));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (residual_valid)
            begin
                if (pending_residuals.size() == 0)
                begin
                    $display("%0t: residual %0d with none expected", $time, residual);
                    mismatches++;
                end
                else
                begin
                    if (residual !== pending_residuals[0])
                    begin
                        $display("%0t: residual mismatch, expected %0d, got %0d",
                                 $time, pending_residuals[0], residual);
                        mismatches++;
                    end
                    void'(pending_residuals.pop_front());
                end
            end
            if (cfg_wr_en)
                grid_cfg = cfg_wr_data;
            if (start && !busy)
                take_command();
        end
    end

    // ends the run if nothing transfers for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (residual_valid || (start && !busy))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // called at a falling edge; returns at the first falling edge after the transfer with busy low
    task automatic issue(input stencil_cmd_t cmd, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        action <= cmd.action;
        row <= cmd.row;
        col <= cmd.col;
        solution_value <= cmd.sol;
        rhs_value <= cmd.rhs;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_residuals.size() != 0)
            @(negedge clk);
        // a trailing load or dropped query may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_side(input logic [CFW-1:0] v);
        cfg_wr_data <= v;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        plan_row_t        plan [N_PLAN];
        stencil_cmd_t     cmd;
        logic [CFW-1:0]   edge_sides [6];
        logic [CFW-1:0]   side_pick;
        int               s;
        int               span;
        int               sr;
        int               sc;
        bit               gappy;

        // side 64: corner wrap, largest and smallest residual
        plan[0]  = '{7'd64, A_LD,  6'd0,  6'd0,  V_MAX, V_MAX, 1'b0, 36'd0};
        plan[1]  = '{7'd64, A_LD,  6'd63, 6'd0,  V_MIN, 32'd0, 1'b0, 36'd0};
        plan[2]  = '{7'd64, A_LD,  6'd1,  6'd0,  V_MIN, 32'd0, 1'b0, 36'd0};
        plan[3]  = '{7'd64, A_LD,  6'd0,  6'd63, V_MIN, 32'd0, 1'b0, 36'd0};
        plan[4]  = '{7'd64, A_LD,  6'd0,  6'd1,  V_MIN, 32'd0, 1'b0, 36'd0};
        plan[5]  = '{7'd64, A_QRY, 6'd0,  6'd0,  32'd0, 32'd0, 1'b1, 36'h4_7FFF_FFFB};
        plan[6]  = '{7'd64, A_LD,  6'd0,  6'd0,  V_MIN, V_MIN, 1'b0, 36'd0};
        plan[7]  = '{7'd64, A_LD,  6'd63, 6'd0,  V_MAX, 32'd0, 1'b0, 36'd0};
        plan[8]  = '{7'd64, A_LD,  6'd1,  6'd0,  V_MAX, 32'd0, 1'b0, 36'd0};
        plan[9]  = '{7'd64, A_LD,  6'd0,  6'd63, V_MAX, 32'd0, 1'b0, 36'd0};
        plan[10] = '{7'd64, A_LD,  6'd0,  6'd1,  V_MAX, 32'd0, 1'b0, 36'd0};
        plan[11] = '{7'd64, A_QRY, 6'd0,  6'd0,  32'd0, 32'd0, 1'b1, 36'hB_8000_0004};
        // far corner
        plan[12] = '{7'd64, A_LD,  6'd63, 6'd63, 32'h1234_5678, 32'hFEDC_BA98,
                     1'b0, 36'd0};
        plan[13] = '{7'd64, A_LD,  6'd62, 6'd63, V_ONE, 32'd0, 1'b0, 36'd0};
        plan[14] = '{7'd64, A_LD,  6'd63, 6'd62, 32'hFFFF_0000, 32'd0, 1'b0, 36'd0};
        plan[15] = '{7'd64, A_QRY, 6'd63, 6'd63, 32'd0, 32'd0, 1'b0, 36'd0};
        // side 4: wrap at the small grid, commands outside it
        plan[16] = '{7'd4,  A_LD,  6'd3,  6'd0,  V_ONE, 32'd0, 1'b0, 36'd0};
        plan[17] = '{7'd4,  A_LD,  6'd0,  6'd3,  V_HALF, 32'd0, 1'b0, 36'd0};
        plan[18] = '{7'd4,  A_QRY, 6'd0,  6'd0,  32'd0, 32'd0, 1'b0, 36'd0};
        plan[19] = '{7'd4,  A_QRY, 6'd4,  6'd0,  32'd0, 32'd0, 1'b0, 36'd0};
        plan[20] = '{7'd4,  A_LD,  6'd0,  6'd5,  V_MAX, V_MAX, 1'b0, 36'd0};
        // out-of-range sides saturate
        plan[21] = '{7'd0,  A_QRY, 6'd0,  6'd0,  32'd0, 32'd0, 1'b0, 36'd0};
        plan[22] = '{7'd127, A_QRY, 6'd63, 6'd63, 32'd0, 32'd0, 1'b0, 36'd0};

        edge_sides[0] = 7'd4;
        edge_sides[1] = 7'd64;
        edge_sides[2] = 7'd0;
        edge_sides[3] = 7'd127;
        edge_sides[4] = 7'd5;
        edge_sides[5] = 7'd3;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_PLAN; i++)
        begin
            if (plan[i].side != grid_cfg)
            begin
                settle();
                write_side(plan[i].side);
            end
            cmd = '{plan[i].action, plan[i].row, plan[i].col, plan[i].sol, plan[i].rhs};
            pin_valid = plan[i].pinned;
            pin_res = plan[i].res;
            issue(cmd, $urandom_range(0, 6));
            pin_valid = 1'b0;
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            settle();
            if (ph < 6)
                side_pick = edge_sides[ph];
            else if ($urandom_range(0, 3) == 0)
                side_pick = CFW'($urandom_range(0, (1 << CFW) - 1));
            else
                side_pick = CFW'($urandom_range(4, 10));
            write_side(side_pick);
            s = side_in_use();
            span = (s < WINDOW) ? s : WINDOW;
            // some windows straddle the wrap edge
            sr = (ph % 3 == 0) ? s - 2 : $urandom_range(0, s - 1);
            sc = (ph % 2 == 0) ? s - 1 : $urandom_range(0, s - 1);
            gappy = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                cmd = next_command(sr, sc, span);
                issue(cmd, gappy ? $urandom_range(0, 6) : 0);
            end
        end

        settle();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
